// ===== rtl/core/bwct_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte window content tester package
// Shared register map, test mode codes, configuration type and the
// character class helpers.
// ----------------------------------------------------------------------------
package bwct_pkg;

  localparam int PATTERN_BYTES_DEF = 16;

  localparam logic [2:0] MODE_ASCII     = 3'd0;
  localparam logic [2:0] MODE_PRINTABLE = 3'd1;
  localparam logic [2:0] MODE_EXACT     = 3'd2;
  localparam logic [2:0] MODE_NOCASE    = 3'd3;
  localparam logic [2:0] MODE_CONTAINS  = 3'd4;

  localparam logic [2:0] REG_TEST_MODE      = 3'd0;
  localparam logic [2:0] REG_WINDOW_OFFSET  = 3'd1;
  localparam logic [2:0] REG_WINDOW_LENGTH  = 3'd2;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [2:0] REG_PATTERN_LOW    = 3'd4;
  localparam logic [2:0] REG_PATTERN_HIGH   = 3'd5;

  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_LF        = 8'd10;
  localparam logic [7:0] CHAR_CR        = 8'd13;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;
  localparam logic [7:0] CHAR_TILDE     = 8'd126;
  localparam logic [7:0] CHAR_HIGH_LO   = 8'd128;
  localparam logic [7:0] CHAR_HIGH_HI   = 8'd254;
  localparam logic [7:0] CHAR_UPPER_A   = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'd90;
  localparam logic [7:0] CASE_OFFSET    = 8'd32;

  typedef struct packed {
    logic [2:0]  test_mode;
    logic [31:0] window_offset;
    logic [15:0] window_length;
    logic [4:0]  pattern_length;
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
  } cfg_t;

  function automatic logic is_ascii_class(input logic [7:0] c);
    return c inside {CHAR_BACKSPACE, CHAR_TAB, CHAR_LF, CHAR_CR, [CHAR_SPACE:CHAR_TILDE]};
  endfunction

  function automatic logic is_print_class(input logic [7:0] c);
    return is_ascii_class(c) || (c inside {[CHAR_HIGH_LO:CHAR_HIGH_HI]});
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) ? c + CASE_OFFSET : c;
  endfunction

endpackage

// ===== rtl/core/byte_window_content_tester.sv =====
// ----------------------------------------------------------------------------
// Byte window content tester
// Streams the bytes of a file and decides one content test on a window.
//
// Usage: bytes enter on the byte channel (data_byte, end_of_stream with
// byte_valid/byte_ready), one word per cycle. A stream gives no result until
// its word marked end_of_stream; then exactly one result word (test_passed)
// leaves on the result channel (result_valid/result_ready), after which the
// stream state is cleared for the next stream. The test is set through the
// APB port: registers at byte addresses 0, 8, ..., 40 (mode, offset, window
// length, pattern length, pattern low and high), 64-bit data.
// A final word waits in the input register, is judged by the evaluator once
// the result register is free, and its verdict is registered there.
// Throughput is one word per cycle while no final word waits on a stalled
// receiver, set by the single input register and evaluation step.
// Reset clears the configuration, the stream state and both channels. When
// the receiver stalls, ordinary words keep flowing; a final word waits in the
// input register until the result register is free.
// ----------------------------------------------------------------------------
module byte_window_content_tester #(
  parameter int PATTERN_BYTES = bwct_pkg::PATTERN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        test_passed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import bwct_pkg::*;

  cfg_t       cfg;
  logic [2:0] reg_index;
  logic       cfg_write;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_free;
  logic       fire;
  logic       pass;

  assign pready    = 1'b1;
  assign reg_index = paddr[5:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_TEST_MODE:      cfg.test_mode      <= pwdata[2:0];
        REG_WINDOW_OFFSET:  cfg.window_offset  <= pwdata[31:0];
        REG_WINDOW_LENGTH:  cfg.window_length  <= pwdata[15:0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= pwdata[4:0];
        REG_PATTERN_LOW:    cfg.pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   cfg.pattern_high   <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_TEST_MODE:      prdata = {61'b0, cfg.test_mode};
      REG_WINDOW_OFFSET:  prdata = {32'b0, cfg.window_offset};
      REG_WINDOW_LENGTH:  prdata = {48'b0, cfg.window_length};
      REG_PATTERN_LENGTH: prdata = {59'b0, cfg.pattern_length};
      REG_PATTERN_LOW:    prdata = cfg.pattern_low;
      REG_PATTERN_HIGH:   prdata = cfg.pattern_high;
      default:            prdata = '0;
    endcase
  end

  assign out_free   = !result_valid || result_ready;
  assign fire       = in_full && (!in_last || out_free);
  assign byte_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_byte <= data_byte;
      in_last <= end_of_stream;
    end
  end

  bwct_eval #(
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_eval (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (fire),
    .data_byte     (in_byte),
    .end_of_stream (in_last),
    .test_passed   (pass)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && in_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      test_passed <= pass;
    end
  end

endmodule

// ===== rtl/core/bwct_eval.sv =====
// ----------------------------------------------------------------------------
// Byte window content tester evaluator
// Holds the per-stream state, judges one byte per step and forms the verdict
// for the final byte of a stream.
// ----------------------------------------------------------------------------
module bwct_eval #(
  parameter int PATTERN_BYTES = bwct_pkg::PATTERN_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  bwct_pkg::cfg_t cfg,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  logic          end_of_stream,
  output logic          test_passed
);
  import bwct_pkg::*;

  localparam int IW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

  logic [31:0]  position;
  logic [31:0]  position_next;
  logic         failed;
  logic         failed_next;
  logic         found;
  logic         found_next;
  logic [15:0]  seen;
  logic [15:0]  seen_next;
  logic [7:0]   recent [PATTERN_BYTES];
  logic [7:0]   recent_shift [PATTERN_BYTES];
  logic         shift_en;

  logic [4:0]   plen;
  logic [15:0]  limit;
  logic         in_window;
  logic [127:0] pat;
  logic [7:0]   pat_byte;
  logic         hit;
  logic [4:0]   sel;

  assign pat      = {cfg.pattern_high, cfg.pattern_low};
  assign plen     = (cfg.pattern_length > 5'(PATTERN_BYTES)) ? 5'(PATTERN_BYTES)
                                                             : cfg.pattern_length;
  assign limit    = (cfg.test_mode == MODE_EXACT || cfg.test_mode == MODE_NOCASE)
                    ? {11'b0, plen} : cfg.window_length;
  assign in_window = (position >= cfg.window_offset) && (seen < limit);
  assign pat_byte = pat[8*seen[3:0] +: 8];

  always_comb begin
    recent_shift[0] = data_byte;
    for (int i = 1; i < PATTERN_BYTES; i++) begin
      recent_shift[i] = recent[i-1];
    end
  end

  always_comb begin
    hit = 1'b1;
    sel = '0;
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      sel = 5'(plen - 5'd1 - 5'(k));
      if (5'(k) < plen && recent_shift[sel[IW-1:0]] != pat[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    failed_next   = failed;
    found_next    = found;
    seen_next     = seen;
    shift_en      = 1'b0;
    position_next = position + 32'd1;
    if (in_window) begin
      case (cfg.test_mode)
        MODE_ASCII: begin
          if (!is_ascii_class(data_byte)) failed_next = 1'b1;
        end
        MODE_PRINTABLE: begin
          if (!is_print_class(data_byte)) failed_next = 1'b1;
        end
        MODE_EXACT: begin
          if (data_byte != pat_byte) failed_next = 1'b1;
        end
        MODE_NOCASE: begin
          if (fold_case(data_byte) != fold_case(pat_byte)) failed_next = 1'b1;
        end
        MODE_CONTAINS: begin
          shift_en = 1'b1;
          if (plen != 5'd0 && ({1'b0, seen} + 17'd1) >= {12'b0, plen} && hit) begin
            found_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
      seen_next = seen + 16'd1;
    end
  end

  always_comb begin
    case (cfg.test_mode)
      MODE_ASCII, MODE_PRINTABLE: test_passed = !failed_next;
      MODE_EXACT, MODE_NOCASE:    test_passed = !failed_next && (seen_next >= {11'b0, plen});
      MODE_CONTAINS:              test_passed = (plen == 5'd0) || found_next;
      default:                    test_passed = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_stream)) begin
      position <= '0;
      failed   <= 1'b0;
      found    <= 1'b0;
      seen     <= '0;
      for (int i = 0; i < PATTERN_BYTES; i++) begin
        recent[i] <= '0;
      end
    end else if (step) begin
      position <= position_next;
      failed   <= failed_next;
      found    <= found_next;
      seen     <= seen_next;
      if (shift_en) begin
        for (int i = 0; i < PATTERN_BYTES; i++) begin
          recent[i] <= recent_shift[i];
        end
      end
    end
  end

endmodule

// ===== verif/window_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window verdict checker
// Watches the byte, result and register ports of the content tester. It keeps
// its own copy of the registers and of the stream state, works out the verdict
// of every stream when its final word is taken, and compares each result word
// with the oldest verdict still outstanding.
// ----------------------------------------------------------------------------
module window_verdict_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic        test_passed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          failures,
  output int          pending,
  output int          verdicts,
  output int          passes
);
  import bwct_pkg::*;

  logic [2:0]  mode_q;
  logic [31:0] offset_q;
  logic [15:0] wlen_q;
  logic [4:0]  plen_q;
  logic [63:0] pat_lo_q;
  logic [63:0] pat_hi_q;

  logic [31:0] position;
  logic        broken;
  logic        found;
  logic [15:0] seen;
  logic [7:0]  history [16];

  logic        verdict_queue [$];
  logic        due_verdict;
  int          mismatches;
  int          judged;
  int          passed;

  function automatic logic text_char(input logic [7:0] c);
    return c == CHAR_BACKSPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR ||
           (c >= CHAR_SPACE && c <= CHAR_TILDE);
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
  endfunction

  function automatic logic [7:0] pattern_at(input int i);
    return (i < 8) ? pat_lo_q[8*i +: 8] : pat_hi_q[8*(i-8) +: 8];
  endfunction

  task automatic clear_stream();
    int k;
    position = '0;
    broken   = 1'b0;
    found    = 1'b0;
    seen     = '0;
    for (k = 0; k < 16; k++) history[k] = '0;
  endtask

  task automatic judge_byte(input logic [7:0] c, input logic last);
    int   plen;
    int   limit;
    int   k;
    logic match;
    logic verdict;
    plen  = (plen_q > 5'd16) ? 16 : int'(plen_q);
    limit = (mode_q == MODE_EXACT || mode_q == MODE_NOCASE) ? plen : int'(wlen_q);
    if (position >= offset_q && int'(seen) < limit) begin
      case (mode_q)
        MODE_ASCII: begin
          if (!text_char(c)) broken = 1'b1;
        end
        MODE_PRINTABLE: begin
          if (!text_char(c) && !(c >= CHAR_HIGH_LO && c <= CHAR_HIGH_HI)) broken = 1'b1;
        end
        MODE_EXACT: begin
          if (c != pattern_at(int'(seen))) broken = 1'b1;
        end
        MODE_NOCASE: begin
          if (lower(c) != lower(pattern_at(int'(seen)))) broken = 1'b1;
        end
        MODE_CONTAINS: begin
          for (k = 15; k > 0; k--) history[k] = history[k-1];
          history[0] = c;
          if (plen > 0 && int'(seen) + 1 >= plen) begin
            match = 1'b1;
            for (k = 0; k < plen; k++) begin
              if (history[plen-1-k] != pattern_at(k)) match = 1'b0;
            end
            if (match) found = 1'b1;
          end
        end
        default: begin
        end
      endcase
      seen = seen + 16'd1;
    end
    position = position + 32'd1;
    if (last) begin
      case (mode_q)
        MODE_ASCII, MODE_PRINTABLE: verdict = !broken;
        MODE_EXACT, MODE_NOCASE:    verdict = !broken && int'(seen) >= plen;
        MODE_CONTAINS:              verdict = (plen == 0) || found;
        default:                    verdict = 1'b0;
      endcase
      verdict_queue.push_back(verdict);
      clear_stream();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_q   = '0;
      offset_q = '0;
      wlen_q   = '0;
      plen_q   = '0;
      pat_lo_q = '0;
      pat_hi_q = '0;
      clear_stream();
      verdict_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_TEST_MODE:      mode_q   = pwdata[2:0];
          REG_WINDOW_OFFSET:  offset_q = pwdata[31:0];
          REG_WINDOW_LENGTH:  wlen_q   = pwdata[15:0];
          REG_PATTERN_LENGTH: plen_q   = pwdata[4:0];
          REG_PATTERN_LOW:    pat_lo_q = pwdata;
          REG_PATTERN_HIGH:   pat_hi_q = pwdata;
          default: begin
          end
        endcase
      end
      if (byte_valid && byte_ready) judge_byte(data_byte, end_of_stream);
      if (result_valid && result_ready) begin
        if (verdict_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("checker: result word with no stream waiting, test_passed %0b",
                     test_passed);
          end
        end else begin
          due_verdict = verdict_queue.pop_front();
          judged++;
          if (due_verdict) passed++;
          if (test_passed !== due_verdict) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("checker: stream %0d: expected test_passed %0b, got %0b",
                       judged, due_verdict, test_passed);
            end
          end
        end
      end
    end
    failures <= mismatches;
    pending  <= verdict_queue.size();
    verdicts <= judged;
    passes   <= passed;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte window content tester testbench
// Feeds byte streams to the tester under a series of register settings: a
// short directed set for the character classes, matching modes and their
// corner cases, then random settings with mostly well-formed streams. The
// sender and receiver run in three idle mixes, the last without idling; the
// checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module testbench;
  import bwct_pkg::*;

  localparam int         ITEMS_TOTAL   = 1450;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         STALL_LIMIT   = 2000;
  localparam logic [2:0] MODE_UNUSED   = 3'd7;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        byte_valid    = 1'b0;
  logic        byte_ready;
  logic [7:0]  data_byte     = '0;
  logic        end_of_stream = 1'b0;
  logic        result_valid;
  logic        result_ready  = 1'b0;
  logic        test_passed;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [5:0]  paddr         = '0;
  logic [63:0] pwdata        = '0;
  logic [63:0] prdata;
  logic        pready;

  int failures;
  int pending;
  int verdicts;
  int passes;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int settings      = 0;
  int stall_cycles  = 0;
  int phase;

  logic [2:0]  cfg_mode;
  logic [31:0] cfg_offset;
  logic [15:0] cfg_wlen;
  logic [4:0]  cfg_plen;
  logic [63:0] cfg_lo;
  logic [63:0] cfg_hi;

  always #2 clk = ~clk;

  byte_window_content_tester i_dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .test_passed   (test_passed),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  window_verdict_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .test_passed   (test_passed),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .failures      (failures),
    .pending       (pending),
    .verdicts      (verdicts),
    .passes        (passes)
  );

  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("testbench: no word moved for %0d cycles", STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(input logic [2:0] mode, input logic [31:0] offset,
                       input logic [15:0] wlen, input logic [4:0] plen,
                       input logic [63:0] lo, input logic [63:0] hi);
    cfg_mode   = mode;
    cfg_offset = offset;
    cfg_wlen   = wlen;
    cfg_plen   = plen;
    cfg_lo     = lo;
    cfg_hi     = hi;
    write_reg(REG_TEST_MODE, 64'(mode));
    write_reg(REG_WINDOW_OFFSET, 64'(offset));
    write_reg(REG_WINDOW_LENGTH, 64'(wlen));
    write_reg(REG_PATTERN_LENGTH, 64'(plen));
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    settings++;
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid    <= 1'b1;
    data_byte     <= value;
    end_of_stream <= last;
    do @(posedge clk); while (!byte_ready);
    items_sent++;
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pat_at(input int i);
    return (i < 8) ? cfg_lo[8*i +: 8] : cfg_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] swap_case(input logic [7:0] c);
    logic [7:0] low;
    low = c | CASE_OFFSET;
    if (low >= CHAR_UPPER_A + CASE_OFFSET && low <= CHAR_UPPER_Z + CASE_OFFSET) begin
      return c ^ CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] class_byte();
    case ($urandom_range(0, 19))
      0: return 8'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       return CHAR_BACKSPACE;
          1:       return CHAR_TAB;
          2:       return CHAR_LF;
          default: return CHAR_CR;
        endcase
      end
      2, 3: begin
        if (cfg_mode == MODE_PRINTABLE) return 8'($urandom_range(128, 254));
        return 8'($urandom_range(32, 126));
      end
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic logic [7:0] near_byte();
    if ($urandom_range(0, 2) == 0) return 8'($urandom);
    return pat_at($urandom_range(0, 15));
  endfunction

  task automatic random_setup();
    logic [2:0]   mode;
    logic [31:0]  offset;
    logic [15:0]  wlen;
    logic [4:0]   plen;
    logic [127:0] pat;
    int           k;
    case ($urandom_range(0, 10))
      0, 1:    mode = MODE_ASCII;
      2, 3:    mode = MODE_PRINTABLE;
      4, 5:    mode = MODE_EXACT;
      6, 7:    mode = MODE_NOCASE;
      8, 9:    mode = MODE_CONTAINS;
      default: mode = MODE_CONTAINS + 3'($urandom_range(1, 3));
    endcase
    case ($urandom_range(0, 19))
      0:       offset = '1;
      1:       offset = $urandom;
      default: offset = $urandom_range(0, 6);
    endcase
    case ($urandom_range(0, 9))
      0:       wlen = '1;
      1:       wlen = '0;
      default: wlen = 16'($urandom_range(1, 20));
    endcase
    case ($urandom_range(0, 9))
      0:       plen = 5'($urandom_range(17, 31));
      1:       plen = '0;
      2:       plen = 5'd16;
      default: plen = 5'($urandom_range(1, 8));
    endcase
    for (k = 0; k < 16; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        pat[8*k +: 8] = 8'($urandom);
      end else begin
        pat[8*k +: 8] = ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_UPPER_A + CASE_OFFSET) +
                        8'($urandom_range(0, 3));
      end
    end
    setup(mode, offset, wlen, plen, pat[63:0], pat[127:64]);
  endtask

  task automatic run_stream();
    logic [7:0] body [$];
    logic [7:0] b;
    logic       flip;
    int         plen;
    int         lead;
    int         count;
    int         cut;
    int         k;
    plen = (cfg_plen > 5'd16) ? 16 : int'(cfg_plen);
    lead = (cfg_offset < 12) ? int'(cfg_offset) : $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) begin
      count = $urandom_range(1, 30);
      for (k = 0; k < count; k++) body.push_back(8'($urandom));
    end else begin
      for (k = 0; k < lead; k++) body.push_back(8'($urandom));
      case (cfg_mode)
        MODE_ASCII, MODE_PRINTABLE: begin
          count = $urandom_range(0, (cfg_wlen < 20) ? int'(cfg_wlen) + 2 : 22);
          for (k = 0; k < count; k++) body.push_back(class_byte());
        end
        MODE_EXACT, MODE_NOCASE, MODE_CONTAINS: begin
          if (cfg_mode == MODE_CONTAINS) begin
            count = $urandom_range(0, (cfg_wlen < 16) ? int'(cfg_wlen) : 16);
            for (k = 0; k < count; k++) body.push_back(near_byte());
          end
          for (k = 0; k < plen; k++) begin
            b    = pat_at(k);
            flip = (cfg_mode == MODE_EXACT) ? ($urandom_range(0, 15) == 0) :
                                              ($urandom_range(0, 1) == 1);
            body.push_back(flip ? swap_case(b) : b);
          end
          if ($urandom_range(0, 5) == 0 && body.size() > 0) begin
            body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
          end
          count = $urandom_range(0, 3);
          for (k = 0; k < count; k++) body.push_back(near_byte());
        end
        default: begin
          count = $urandom_range(1, 8);
          for (k = 0; k < count; k++) body.push_back(8'($urandom));
        end
      endcase
      if ($urandom_range(0, 5) == 0 && body.size() > 1) begin
        cut = $urandom_range(1, body.size() - 1);
        while (body.size() > cut) b = body.pop_back();
      end
    end
    if (body.size() == 0) body.push_back(8'($urandom));
    for (k = 0; k < body.size(); k++) send_byte(body[k], k == body.size() - 1);
  endtask

  initial begin
    send_idle_pct = 19;
    recv_idle_pct = 48;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: ascii mode with an empty window.
    send_byte(8'hFF, 1'b1);
    drain();

    setup(MODE_ASCII, 32'd0, 16'd4, 5'd0, 64'd0, 64'd0);
    send_byte(CHAR_BACKSPACE, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_TILDE, 1'b0);
    send_byte(CHAR_SPACE, 1'b1);
    send_byte(8'h7F, 1'b1);
    drain();

    setup(MODE_PRINTABLE, 32'd0, 16'd3, 5'd0, 64'd0, 64'd0);
    send_byte(CHAR_HIGH_LO, 1'b0);
    send_byte(CHAR_HIGH_HI, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    setup(MODE_EXACT, 32'd1, 16'd0, 5'd2, 64'h4261, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h42, 1'b1);
    drain();

    write_reg(REG_TEST_MODE, 64'(MODE_NOCASE));
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h62, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h61, 1'b1);
    drain();

    setup(MODE_CONTAINS, 32'd0, 16'd3, 5'd3, 64'h63_6261, 64'd0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    drain();

    setup(MODE_EXACT, 32'd0, 16'd0, 5'd0, 64'h55, 64'd0);
    send_byte(8'h55, 1'b1);
    drain();

    write_reg(REG_TEST_MODE, 64'(MODE_UNUSED));
    send_byte(8'h41, 1'b1);
    drain();

    // The offset moves while a stream is half way through.
    setup(MODE_ASCII, 32'd0, 16'd5, 5'd0, 64'd0, 64'd0);
    send_byte(8'h41, 1'b0);
    drain();
    write_reg(REG_WINDOW_OFFSET, 64'd10);
    send_byte(8'h00, 1'b1);
    drain();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 19 : 0;
      while (items_sent < (phase + 1) * ITEMS_TOTAL / 3) begin
        random_setup();
        repeat ($urandom_range(4, 12)) run_stream();
        drain();
      end
    end

    $display("testbench: %0d bytes in %0d streams under %0d register settings, %0d passed",
             items_sent, verdicts, settings, passes);
    $display("testbench: %0d verdict mismatches, %0d verdicts still outstanding",
             failures, pending);
    if (failures == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
